// ===== hdl/pyzh_pkg.sv =====
// Shared types and constants for the pinyin to zhuyin prefix-match core.
package pyzh_pkg;

    localparam int unsigned KEY_CHARS = 6;
    localparam int unsigned KEY_BITS  = 8 * KEY_CHARS;
    localparam int unsigned LEN_BITS  = 3;
    localparam int unsigned CODE_BITS = 16;
    localparam int unsigned CLEN_BITS = 2;

    typedef enum logic [1:0] {
        OP_LOAD_INITIAL = 2'd0,
        OP_LOAD_FINAL   = 2'd1,
        OP_CONVERT      = 2'd2,
        OP_NONE         = 2'd3
    } opcode_t;

    typedef enum logic {
        REG_INITIAL_COUNT = 1'b0,
        REG_FINAL_COUNT   = 1'b1
    } reg_index_t;

    // codes stored first character in the low byte
    localparam logic [15:0] CODE_J0 = 16'h306A;
    localparam logic [15:0] CODE_M0 = 16'h306D;
    localparam logic [15:0] CODE_F  = 16'h0066;
    localparam logic [15:0] CODE_R  = 16'h0072;
    localparam logic [15:0] CODE_V  = 16'h0076;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [5:0]           entry_index;
        logic [KEY_BITS-1:0]  entry_key;
        logic [LEN_BITS-1:0]  entry_key_length;
        logic [CODE_BITS-1:0] entry_code;
        logic [CLEN_BITS-1:0] entry_code_length;
        logic [KEY_BITS-1:0]  syllable;
        logic [LEN_BITS-1:0]  syllable_length;
    } req_item_t;

    typedef struct packed {
        logic [31:0] code_text;
        logic [2:0]  code_length;
    } rsp_item_t;

endpackage

// ===== hdl/pyzh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pyzh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/pinyin_to_zhuyin_prefix_match_core.sv =====
// Top level: pinyin syllable to key-code conversion by first-prefix table search.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  req     | in        | req_valid / req_stall  | pyzh_pkg::req_item_t (load/convert)
//  rsp     | out       | rsp_valid / rsp_stall  | pyzh_pkg::rsp_item_t (code text)
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data (table counts)
//
// A load item is written straight into the table RAM.
// A convert item scans the initials table, then the finals table; a table scan
// stops at the first entry that matches, or after all n searched entries when
// none of them does.
// The scan reads one entry per cycle from each RAM and compares it the next cycle.
// Reset clears counts, control and the output slot; RAM contents stay undefined.
// req_stall is high while a conversion is running; a held result in the output
// register does not block new items until the next result needs the slot.
module pinyin_to_zhuyin_prefix_match_core #(
    parameter int unsigned MAX_INITIALS = 32,
    parameter int unsigned MAX_FINALS   = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pyzh_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output pyzh_pkg::rsp_item_t rsp,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data
);

    localparam int unsigned KEY_CHARS = pyzh_pkg::KEY_CHARS;
    localparam int unsigned KEY_W = pyzh_pkg::KEY_BITS;
    localparam int unsigned LEN_W = pyzh_pkg::LEN_BITS;
    localparam int unsigned CODE_W = pyzh_pkg::CODE_BITS;
    localparam int unsigned CLEN_W = pyzh_pkg::CLEN_BITS;
    localparam int unsigned ENT_W = KEY_W + LEN_W + CODE_W + CLEN_W;
    localparam int unsigned IA_W = MAX_INITIALS > 1 ? $clog2(MAX_INITIALS) : 1;
    localparam int unsigned FA_W = MAX_FINALS > 1 ? $clog2(MAX_FINALS) : 1;
    localparam int unsigned MAXN = MAX_FINALS > MAX_INITIALS ? MAX_FINALS : MAX_INITIALS;
    localparam int unsigned SC_W = $clog2(MAXN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_FIN,
        S_OUT
    } state_t;

    // RAM word layout: {code_len, code, key_len, key}
    typedef struct packed {
        logic [CLEN_W-1:0] code_len;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  key_len;
        logic [KEY_W-1:0]  key;
    } entry_t;

    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_CHARS; b++)
        begin
            if (LEN_W'(b) < len)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_key(input logic [LEN_W-1:0] len);
        if ({1'b0, len} > 4'(KEY_CHARS))
        begin
            return LEN_W'(KEY_CHARS);
        end
        return len;
    endfunction

    function automatic logic prefix_hit(input logic [KEY_W-1:0] key,
                                        input logic [LEN_W-1:0] klen,
                                        input logic [KEY_W-1:0] text,
                                        input logic [LEN_W-1:0] tlen);
        logic ok;
        ok = (klen <= tlen);
        for (int b = 0; b < KEY_CHARS; b++)
        begin
            if (LEN_W'(b) < klen && key[8*b +: 8] != text[8*b +: 8])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // ---------------- registers ----------------
    state_t                state_reg;
    logic [5:0]            icount_reg;
    logic [6:0]            fcount_reg;
    logic [SC_W-1:0]       scan_reg;
    logic                  rd_v_reg;
    logic [KEY_W-1:0]      text_reg;
    logic [LEN_W-1:0]      tlen_reg;
    logic [CODE_W-1:0]     icode_reg;
    logic [CLEN_W-1:0]     ilen_reg;
    logic [CODE_W-1:0]     fcode_reg;
    logic [CLEN_W-1:0]     flen_reg;
    logic                  rsp_valid_reg;
    pyzh_pkg::rsp_item_t   rsp_reg;

    // ---------------- request side ----------------
    logic                  req_take;
    logic [LEN_W-1:0]      klen_c;
    logic [LEN_W-1:0]      slen_c;
    logic [CLEN_W-1:0]     clen_c;
    logic [CODE_W-1:0]     code_c;
    logic [7:0]            idx8;
    entry_t                wr_entry;
    logic                  wr_init;
    logic                  wr_fin;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;

    assign klen_c = clamp_key(req.entry_key_length);
    assign slen_c = clamp_key(req.syllable_length);
    assign clen_c = (req.entry_code_length == 2'd3) ? 2'd2 : req.entry_code_length;
    assign code_c = req.entry_code & {{8{clen_c == 2'd2}}, {8{clen_c != 2'd0}}};
    assign idx8   = {2'b0, req.entry_index};

    assign wr_entry.code_len = clen_c;
    assign wr_entry.code     = code_c;
    assign wr_entry.key_len  = klen_c;
    assign wr_entry.key      = req.entry_key & byte_mask(klen_c);

    assign wr_init = req_take && req.opcode == pyzh_pkg::OP_LOAD_INITIAL
                     && idx8 < 8'(MAX_INITIALS);
    assign wr_fin  = req_take && req.opcode == pyzh_pkg::OP_LOAD_FINAL
                     && idx8 < 8'(MAX_FINALS);

    // ---------------- table memories ----------------
    logic [ENT_W-1:0] init_rdata;
    logic [ENT_W-1:0] fin_rdata;

    pyzh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_INITIALS)
    ) u_init_ram (
        .clk   (clk),
        .we    (wr_init),
        .waddr (idx8[IA_W-1:0]),
        .wdata (wr_entry),
        .raddr (scan_reg[IA_W-1:0]),
        .rdata (init_rdata)
    );

    pyzh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_FINALS)
    ) u_fin_ram (
        .clk   (clk),
        .we    (wr_fin),
        .waddr (idx8[FA_W-1:0]),
        .wdata (wr_entry),
        .raddr (scan_reg[FA_W-1:0]),
        .rdata (fin_rdata)
    );

    // Writes happen only in idle and read data is used only during a scan, so no
    // RAM access to the same entry can overlap.

    // ---------------- scan control ----------------
    logic [SC_W-1:0] ni_lim;
    logic [SC_W-1:0] nf_lim;
    logic [SC_W-1:0] scan_lim;
    logic            issue;
    entry_t          cur;
    logic            hit;

    assign ni_lim = ({2'b0, icount_reg} > 8'(MAX_INITIALS)) ? SC_W'(MAX_INITIALS)
                                                            : SC_W'(icount_reg);
    assign nf_lim = ({1'b0, fcount_reg} > 8'(MAX_FINALS)) ? SC_W'(MAX_FINALS)
                                                          : SC_W'(fcount_reg);
    assign scan_lim = (state_reg == S_FIN) ? nf_lim : ni_lim;
    assign issue    = scan_reg < scan_lim;
    assign cur      = (state_reg == S_FIN) ? entry_t'(fin_rdata) : entry_t'(init_rdata);
    assign hit      = rd_v_reg && prefix_hit(cur.key, cur.key_len, text_reg, tlen_reg);

    // final j0 becomes m0 after a single-letter f, r or v initial
    logic                  fix_m0;
    logic [CODE_W-1:0]     fcode_fx;
    logic [31:0]           text_out;

    assign fix_m0 = flen_reg == 2'd2 && fcode_reg == pyzh_pkg::CODE_J0
                    && ilen_reg == 2'd1
                    && (icode_reg == pyzh_pkg::CODE_F || icode_reg == pyzh_pkg::CODE_R
                        || icode_reg == pyzh_pkg::CODE_V);
    assign fcode_fx = fix_m0 ? pyzh_pkg::CODE_M0 : fcode_reg;
    assign text_out = {16'b0, icode_reg} | ({16'b0, fcode_fx} << {ilen_reg, 3'b000});

    // ---------------- state machine ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            icount_reg    <= '0;
            fcount_reg    <= '0;
            scan_reg      <= '0;
            rd_v_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pyzh_pkg::REG_INITIAL_COUNT: icount_reg <= cfg_data[5:0];
                    pyzh_pkg::REG_FINAL_COUNT:   fcount_reg <= cfg_data;
                    default:                     ;
                endcase
            end

            // output slot: a new result enters, or the held one leaves
            if (state_reg == S_OUT && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_take && req.opcode == pyzh_pkg::OP_CONVERT)
                    begin
                        text_reg  <= req.syllable & byte_mask(slen_c);
                        tlen_reg  <= slen_c;
                        scan_reg  <= '0;
                        rd_v_reg  <= 1'b0;
                        state_reg <= S_INIT;
                    end
                end

                S_INIT, S_FIN:
                begin
                    // without a hit, nothing left to issue means no searched entry
                    // matched: the implied empty entry matches
                    priority if (hit || !issue)
                    begin
                        scan_reg <= '0;
                        rd_v_reg <= 1'b0;
                        if (state_reg == S_INIT)
                        begin
                            icode_reg <= hit ? cur.code : '0;
                            ilen_reg  <= hit ? cur.code_len : '0;
                            if (hit)
                            begin
                                text_reg <= text_reg >> {cur.key_len, 3'b000};
                                tlen_reg <= tlen_reg - cur.key_len;
                            end
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            fcode_reg <= hit ? cur.code : '0;
                            flen_reg  <= hit ? cur.code_len : '0;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + SC_W'(1);
                        rd_v_reg <= 1'b1;
                    end
                end

                S_OUT:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg.code_text   <= text_out;
                        rsp_reg.code_length <= {1'b0, ilen_reg} + {1'b0, flen_reg};
                        state_reg           <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== verif/pinyin_to_zhuyin_prefix_match_core_test.sv =====
// Self-checking testbench for the pinyin to zhuyin prefix-match core.
`timescale 1ns / 100ps

module pinyin_to_zhuyin_prefix_match_core_test;

    // table geometry of the instance under test (default parameters)
    localparam int unsigned MAX_INI   = 32;
    localparam int unsigned MAX_FIN   = 64;
    localparam int unsigned KEY_CHARS = 6;

    // settle time, longer than the worst-case conversion
    localparam int SETTLE = 120;
    localparam int unsigned LIMIT = 1_000_000;

    // random part: PHASES count settings, PER_PHASE counted items each
    localparam int PHASES    = 10;
    localparam int PER_PHASE = 145;

    // hold-off of the result side, to back the core up into its input
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 300;

    // small letter set so keys and syllables collide often
    localparam string LETTERS = "anfrvgou";

    typedef struct {
        logic [47:0] key;
        int unsigned klen;
        logic [15:0] code;
        int unsigned clen;
    } entry_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                req_valid   = 1'b0;
    logic                req_stall;
    pyzh_pkg::req_item_t req         = '0;
    logic                rsp_valid;
    logic                rsp_stall   = 1'b0;
    pyzh_pkg::rsp_item_t rsp;
    logic                cfg_we      = 1'b0;
    logic                cfg_index   = 1'b0;
    logic [6:0]          cfg_data    = '0;

    // mirror of the core's tables and counts
    entry_t      initials [MAX_INI];
    entry_t      finals   [MAX_FIN];
    int unsigned searched_initials = 0;
    int unsigned searched_finals   = 0;

    pyzh_pkg::req_item_t pending_items [$];
    pyzh_pkg::rsp_item_t expected_codes [$];

    bit          calm         = 1'b0;   // no idling on either side
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    int          results_seen = 0;
    int          mismatches   = 0;
    int unsigned cycles       = 0;

    pinyin_to_zhuyin_prefix_match_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [47:0] byte_mask(int unsigned n);
        logic [47:0] m;
        m = '0;
        for (int b = 0; b < n && b < 6; b++)
            m[b*8 +: 8] = 8'hFF;
        return m;
    endfunction

    // key must not be longer than the text, and its characters must agree
    function automatic bit key_fits(entry_t e, logic [47:0] text, int unsigned tlen);
        if (e.klen > tlen)
            return 1'b0;
        return ((e.key ^ text) & byte_mask(e.klen)) == '0;
    endfunction

    function automatic pyzh_pkg::rsp_item_t predict_code(pyzh_pkg::req_item_t it);
        pyzh_pkg::rsp_item_t r;
        logic [47:0] syl;
        logic [47:0] rest;
        logic [15:0] icode;
        logic [15:0] fcode;
        int unsigned slen;
        int unsigned rlen;
        int unsigned ilen;
        int unsigned flen;
        int unsigned used;
        int unsigned ni;
        int unsigned nf;
        slen  = (it.syllable_length > KEY_CHARS) ? KEY_CHARS : it.syllable_length;
        syl   = it.syllable & byte_mask(slen);
        ni    = (searched_initials > MAX_INI) ? MAX_INI : searched_initials;
        nf    = (searched_finals > MAX_FIN) ? MAX_FIN : searched_finals;
        icode = '0;
        fcode = '0;
        ilen  = 0;
        flen  = 0;
        used  = 0;
        // first initial whose key prefixes the syllable; none means empty
        for (int i = 0; i < ni; i++)
        begin
            if (key_fits(initials[i], syl, slen))
            begin
                icode = initials[i].code;
                ilen  = initials[i].clen;
                used  = initials[i].klen;
                break;
            end
        end
        rest = syl >> (8 * used);
        rlen = slen - used;
        for (int i = 0; i < nf; i++)
        begin
            if (key_fits(finals[i], rest, rlen))
            begin
                fcode = finals[i].code;
                flen  = finals[i].clen;
                break;
            end
        end
        // j0 after a lone f, r or v turns into m0
        if (flen == 2 && fcode == pyzh_pkg::CODE_J0 && ilen == 1 &&
            (icode == pyzh_pkg::CODE_F || icode == pyzh_pkg::CODE_R ||
             icode == pyzh_pkg::CODE_V))
            fcode = pyzh_pkg::CODE_M0;
        r.code_text   = {16'h0, icode} | ({16'h0, fcode} << (8 * ilen));
        r.code_length = 3'(ilen + flen);
        return r;
    endfunction

    // accepted item: update the table mirror or queue the expected code
    function automatic void mirror_item(pyzh_pkg::req_item_t it);
        entry_t      e;
        logic [47:0] cm;
        e.klen = (it.entry_key_length > KEY_CHARS) ? KEY_CHARS : it.entry_key_length;
        e.clen = (it.entry_code_length > 2) ? 2 : it.entry_code_length;
        e.key  = it.entry_key & byte_mask(e.klen);
        cm     = byte_mask(e.clen);
        e.code = it.entry_code & cm[15:0];
        case (pyzh_pkg::opcode_t'(it.opcode))
            pyzh_pkg::OP_LOAD_INITIAL:
                if (it.entry_index < MAX_INI)
                    initials[it.entry_index] = e;
            pyzh_pkg::OP_LOAD_FINAL:
                if (it.entry_index < MAX_FIN)
                    finals[it.entry_index] = e;
            pyzh_pkg::OP_CONVERT:
                expected_codes.push_back(predict_code(it));
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------

    // every field random, so bits outside the used ones toggle too
    function automatic pyzh_pkg::req_item_t junk_item();
        return pyzh_pkg::req_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    endfunction

    // first character in the low byte
    function automatic logic [47:0] pack_text(string s);
        logic [47:0] t;
        t = '0;
        for (int i = 0; i < s.len() && i < 6; i++)
            t[i*8 +: 8] = s[i];
        return t;
    endfunction

    // n letters over base; whatever base holds above them is left there
    function automatic logic [47:0] spell(int unsigned n, logic [47:0] base);
        logic [47:0] t;
        t = base;
        for (int b = 0; b < n && b < 6; b++)
            t[b*8 +: 8] = LETTERS[$urandom_range(0, 7)];
        return t;
    endfunction

    function automatic pyzh_pkg::req_item_t entry_of(pyzh_pkg::opcode_t op,
                                                     logic [5:0] idx, string key,
                                                     string code);
        pyzh_pkg::req_item_t it;
        logic [47:0]         c;
        it                   = junk_item();
        c                    = pack_text(code);
        it.opcode            = op;
        it.entry_index       = idx;
        it.entry_key         = pack_text(key);
        it.entry_key_length  = 3'(key.len());
        it.entry_code        = c[15:0];
        it.entry_code_length = 2'(code.len());
        return it;
    endfunction

    function automatic pyzh_pkg::req_item_t convert_of(string s);
        pyzh_pkg::req_item_t it;
        it                 = junk_item();
        it.opcode          = pyzh_pkg::OP_CONVERT;
        it.syllable        = pack_text(s);
        it.syllable_length = 3'(s.len());
        return it;
    endfunction

    function automatic pyzh_pkg::req_item_t random_entry(pyzh_pkg::opcode_t op,
                                                         logic [5:0] idx);
        pyzh_pkg::req_item_t it;
        int unsigned         n;
        it             = junk_item();
        it.opcode      = op;
        it.entry_index = idx;
        case ($urandom_range(0, 23))
            0:       n = 0;      // always matches
            1:       n = 7;      // saturates to six
            default: n = $urandom_range(1, (op == pyzh_pkg::OP_LOAD_INITIAL) ? 2 : 3);
        endcase
        it.entry_key_length = 3'(n);
        it.entry_key = spell(n, $urandom_range(0, 1) ? it.entry_key : '0);
        // keep high byte as is for one-letter codes
        case ($urandom_range(0, 9))
            0:
            begin
                it.entry_code[7:0] = pyzh_pkg::CODE_F[7:0];
                it.entry_code_length = 2'd1;
            end
            1:
            begin
                it.entry_code[7:0] = pyzh_pkg::CODE_R[7:0];
                it.entry_code_length = 2'd1;
            end
            2:
            begin
                it.entry_code[7:0] = pyzh_pkg::CODE_V[7:0];
                it.entry_code_length = 2'd1;
            end
            3, 4:
            begin
                it.entry_code = pyzh_pkg::CODE_J0;
                it.entry_code_length = 2'd2;
            end
            5:
            begin
                it.entry_code = pyzh_pkg::CODE_M0;
                it.entry_code_length = 2'd2;
            end
            default:
                ;   // random code, random length up to the saturating 3
        endcase
        return it;
    endfunction

    function automatic pyzh_pkg::req_item_t random_syllable();
        pyzh_pkg::req_item_t it;
        int unsigned         n;
        it                 = junk_item();
        it.opcode          = pyzh_pkg::OP_CONVERT;
        n                  = $urandom_range(0, 7);
        it.syllable_length = 3'(n);
        it.syllable        = spell(n, $urandom_range(0, 1) ? it.syllable : '0);
        return it;
    endfunction

    // mostly loads and conversions; an unused opcode now and then as noise
    task automatic queue_random_items(int n);
        pyzh_pkg::req_item_t it;
        int                  made;
        made = 0;
        while (made < n)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    it        = junk_item();
                    it.opcode = pyzh_pkg::OP_NONE;
                    made--;
                end
                1, 2, 3, 4:
                    it = random_entry(pyzh_pkg::OP_LOAD_INITIAL,
                                      ($urandom_range(0, 7) == 0) ?
                                      6'($urandom_range(32, 63)) :
                                      6'($urandom_range(0, 31)));
                5, 6, 7, 8:
                    it = random_entry(pyzh_pkg::OP_LOAD_FINAL, 6'($urandom_range(0, 63)));
                default:
                    it = random_syllable();
            endcase
            pending_items.push_back(it);
            made++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: pops pending items, holds each until accepted
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : sender
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left   = 0;
        end
        else if (!(req_valid && req_stall))
        begin
            // item on the port was taken at this edge
            if (req_valid)
                mirror_item(req);
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_items.size() == 0)
                req_valid <= 1'b0;
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap_left   = $urandom_range(0, 16);
                req_valid <= 1'b0;
            end
            else
            begin
                req_valid <= 1'b1;
                req       <= pending_items.pop_front();
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks results in order, drives random stalls
    // ------------------------------------------------------------------

    function automatic void flag_result(string why, pyzh_pkg::rsp_item_t want,
                                        pyzh_pkg::rsp_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected text %h len %0d, got text %h len %0d", $time, why,
                     want.code_text, want.code_length, got.code_text, got.code_length);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : receiver
        pyzh_pkg::rsp_item_t want;
        bit                  stall_next;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left  = 0;
            hold_left   = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_codes.size() == 0)
                    flag_result("result with nothing pending", '0, rsp);
                else
                begin
                    want = expected_codes.pop_front();
                    if (rsp.code_text !== want.code_text ||
                        rsp.code_length !== want.code_length)
                        flag_result("code mismatch", want, rsp);
                end
            end
            // one long hold-off; the sender keeps offering meanwhile
            if (!hold_done && !calm && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            rsp_stall <= stall_next;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("pinyin_to_zhuyin_prefix_match_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    // wait for the core to go idle: nothing queued, offered or outstanding,
    // then let a trailing load finish
    task automatic settle();
        while (pending_items.size() != 0 || req_valid || expected_codes.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(pyzh_pkg::reg_index_t idx, logic [6:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == pyzh_pkg::REG_INITIAL_COUNT)
            searched_initials = value[5:0];
        else
            searched_finals = value;
    endtask

    task automatic set_counts(logic [6:0] ini, logic [6:0] fin);
        write_reg(pyzh_pkg::REG_INITIAL_COUNT, ini);
        write_reg(pyzh_pkg::REG_FINAL_COUNT, fin);
    endtask

    initial
    begin : stimulus
        pyzh_pkg::req_item_t it;
        for (int i = 0; i < MAX_INI; i++)
            initials[i] = '{key: '0, klen: 0, code: '0, clen: 0};
        for (int i = 0; i < MAX_FIN; i++)
            finals[i] = '{key: '0, klen: 0, code: '0, clen: 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // fill every entry of both tables first, so no search ever reaches
        // an entry that was never written, whatever the counts
        for (int i = 0; i < MAX_INI; i++)
            pending_items.push_back(random_entry(pyzh_pkg::OP_LOAD_INITIAL, 6'(i)));
        for (int i = 0; i < MAX_FIN; i++)
            pending_items.push_back(random_entry(pyzh_pkg::OP_LOAD_FINAL, 6'(i)));
        settle();
        set_counts(7'(MAX_INI), 7'(MAX_FIN));

        // directed: f/r/v with j0 turn into m0, a two-letter code does not
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_INITIAL, 6'd0, "f", "f"));
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_INITIAL, 6'd1, "r", "r"));
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_INITIAL, 6'd2, "v", "v"));
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_INITIAL, 6'd3, "zh", "ff"));
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_FINAL, 6'd0, "ong", "j0"));
        pending_items.push_back(convert_of("fong"));
        pending_items.push_back(convert_of("rong"));
        pending_items.push_back(convert_of("vong"));
        pending_items.push_back(convert_of("zhong"));
        pending_items.push_back(convert_of("ong"));
        // all-ones key and code with over-long lengths
        it                   = entry_of(pyzh_pkg::OP_LOAD_INITIAL, 6'd4, "", "");
        it.entry_key         = '1;
        it.entry_key_length  = '1;
        it.entry_code        = '1;
        it.entry_code_length = '1;
        pending_items.push_back(it);
        it                 = convert_of("");
        it.syllable        = '1;
        it.syllable_length = '1;
        pending_items.push_back(it);
        // initials index past the table: dropped
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_INITIAL, 6'd63, "f", "q"));
        // final key longer than what is left of the text
        pending_items.push_back(convert_of("f"));
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_FINAL, 6'd63, "u", ""));
        pending_items.push_back(pyzh_pkg::req_item_t'('1));   // unused opcode, all ones
        pending_items.push_back(convert_of(""));
        pending_items.push_back(entry_of(pyzh_pkg::OP_LOAD_INITIAL, 6'd5, "", "b"));
        pending_items.push_back(convert_of("ab"));
        pending_items.push_back(convert_of("fu"));
        settle();

        // random phases, each under its own pair of counts; the first few hit
        // empty tables, counts past the table size, full tables and one entry
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_counts(7'd0, 7'd0);
                1:       set_counts(7'h7F, 7'h7F);
                2:       set_counts(7'(MAX_INI), 7'(MAX_FIN));
                3:       set_counts(7'd1, 7'd1);
                4:       set_counts(7'd63, 7'd0);
                default: set_counts(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            endcase
            if (p == PHASES - 1)
                calm = 1'b1;
            queue_random_items(PER_PHASE);
            settle();
        end

        if (mismatches == 0)
            $display("pinyin_to_zhuyin_prefix_match_core verification clean");
        else
            $display("pinyin_to_zhuyin_prefix_match_core verification failed");
        $finish;
    end

endmodule

// ===== pinyin_to_zhuyin_prefix_match_core.f =====
hdl/pyzh_pkg.sv
hdl/pyzh_ram.sv
hdl/pinyin_to_zhuyin_prefix_match_core.sv
verif/pinyin_to_zhuyin_prefix_match_core_test.sv
